// ===== rtl/blg_pkg.sv =====
// shared types and constants for the battery level gauge
// used by blg_div, blg_dp, blg_ctrl and battery_level_gauge_top
`timescale 1ns / 1ps

package blg_pkg;

    localparam int GROUP_SIZE_DEF = 8;

    localparam int PIN_W  = 12;
    localparam int MV_W   = 14;
    localparam int PCT_W  = 7;
    localparam int IDX_W  = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // divider: numerator holds diff * 100
    localparam int NUM_W = 21;
    localparam int DEN_W = MV_W;
    localparam int QW    = 12;
    localparam int DSH_W = DEN_W + QW - 1;
    localparam int QC_W  = $clog2(QW);

    localparam logic [MV_W-1:0]  FULL_RST   = MV_W'(4200);
    localparam logic [MV_W-1:0]  EMPTY_RST  = MV_W'(3000);
    localparam logic [MV_W-1:0]  CHARGE_RST = MV_W'(4050);
    localparam logic [PCT_W-1:0] PCT_MAX    = PCT_W'(100);
    localparam logic [PCT_W-1:0] PCT_MIN    = PCT_W'(0);
    localparam logic [NUM_W-1:0] PCT_SCALE  = NUM_W'(100);
    localparam logic [MV_W-1:0]  DIV_RATIO  = MV_W'(3);
    localparam logic [MV_W+2:0]  EMA_OLD    = (MV_W+3)'(7);

    typedef enum logic [IDX_W-1:0] {
        REG_FULL   = 2'd0,
        REG_EMPTY  = 2'd1,
        REG_CHARGE = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic acc;
        logic mean;
        logic ema;
        logic eval;
        logic pct_start;
        logic pct_load;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic last_in_group;
        logic div_done;
        logic need_div;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/blg_div.sv =====
// restoring divider, one quotient bit per cycle, quotient below 2**QW
// depends on blg_pkg
`timescale 1ns / 1ps

module blg_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [blg_pkg::NUM_W-1:0]   i_num,
    input  logic [blg_pkg::DEN_W-1:0]   i_den,
    output logic [blg_pkg::QW-1:0]      o_q,
    output logic                        o_done
);

    logic [blg_pkg::DSH_W-1:0] r_rem, n_rem;
    logic [blg_pkg::DSH_W-1:0] r_dsh, n_dsh;
    logic [blg_pkg::QW-1:0]    r_q, n_q;
    logic [blg_pkg::QC_W-1:0]  r_cnt, n_cnt;
    logic                      r_busy, n_busy;
    logic                      r_done, n_done;
    logic                      w_fit;

    assign w_fit = (r_rem >= r_dsh);

    always_comb begin
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = blg_pkg::DSH_W'(i_num);
            n_dsh  = blg_pkg::DSH_W'(i_den) << (blg_pkg::QW - 1);
            n_q    = '0;
            n_cnt  = blg_pkg::QC_W'(blg_pkg::QW - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_fit) begin
                n_rem = r_rem - r_dsh;
            end
            n_q   = {r_q[blg_pkg::QW-2:0], w_fit};
            n_dsh = r_dsh >> 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_q   <= n_q;
    end

    assign o_q    = r_q;
    assign o_done = r_done;

endmodule

// ===== rtl/blg_dp.sv =====
// datapath: group accumulator, config registers, average, percent and output register
// depends on blg_pkg and blg_div
`timescale 1ns / 1ps

module blg_dp #(
    parameter int GROUP_SIZE = blg_pkg::GROUP_SIZE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  blg_pkg::t_dp_cmd                  i_cmd,
    output blg_pkg::t_dp_stat                 o_stat,
    input  logic                              i_cfg_we,
    input  logic [blg_pkg::IDX_W-1:0]         i_cfg_idx,
    input  logic [blg_pkg::MV_W-1:0]          i_cfg_data,
    input  logic [blg_pkg::PIN_W-1:0]         i_pin_mv,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [blg_pkg::PCT_W-1:0]         o_percent,
    output logic                              o_charging,
    output logic [blg_pkg::MV_W-1:0]          o_battery_mv
);

    localparam int CNT_W = $clog2(GROUP_SIZE + 1);
    localparam int SUM_W = blg_pkg::PIN_W + CNT_W;

    // group mean by reciprocal multiplication, exact for every group sum
    localparam int RCP_SH = SUM_W + CNT_W;
    localparam int RCP_W  = RCP_SH + 1;
    localparam int PROD_W = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP = RCP_W'((2 ** RCP_SH + GROUP_SIZE - 1) / GROUP_SIZE);

    logic [blg_pkg::MV_W-1:0]  r_full, r_empty, r_charge;
    logic [SUM_W-1:0]          r_sum;
    logic [CNT_W-1:0]          r_cnt;
    logic [blg_pkg::PIN_W-1:0] r_mean;
    logic [blg_pkg::MV_W-1:0]  r_smooth;
    logic                      r_primed;
    logic [blg_pkg::MV_W-1:0]  r_diff;
    logic [blg_pkg::PCT_W-1:0] r_pct;
    logic                      r_ovalid;
    logic [blg_pkg::PCT_W-1:0] r_opct;
    logic                      r_ochg;
    logic [blg_pkg::MV_W-1:0]  r_omv;

    logic                      w_div_start;
    logic [blg_pkg::NUM_W-1:0] w_div_num;
    logic [blg_pkg::DEN_W-1:0] w_div_den;
    logic [blg_pkg::QW-1:0]    w_q;
    logic                      w_div_done;

    logic [PROD_W-1:0]         w_prod;
    logic [blg_pkg::PIN_W-1:0] w_mean;
    logic [blg_pkg::MV_W-1:0]  w_bat;
    logic [blg_pkg::MV_W+2:0]  w_ema;
    logic [blg_pkg::MV_W:0]    w_diff;
    logic [blg_pkg::MV_W-1:0]  w_span;
    logic                      w_span_empty;
    logic                      w_diff_neg;
    logic                      w_diff_ge;
    logic [blg_pkg::PCT_W-1:0] w_eval_pct;
    logic                      w_out_free;

    assign w_prod = PROD_W'(r_sum) * PROD_W'(RCP);
    assign w_mean = w_prod[RCP_SH +: blg_pkg::PIN_W];
    assign w_bat  = blg_pkg::MV_W'(r_mean) * blg_pkg::DIV_RATIO;
    assign w_ema  = (blg_pkg::EMA_OLD * (blg_pkg::MV_W+3)'(r_smooth)
                    + (blg_pkg::MV_W+3)'(w_bat)) >> 3;
    assign w_diff = {1'b0, r_smooth} - {1'b0, r_empty};
    assign w_span = r_full - r_empty;
    assign w_span_empty = (r_full <= r_empty);
    assign w_diff_neg   = w_diff[blg_pkg::MV_W];
    assign w_diff_ge    = (w_diff[blg_pkg::MV_W-1:0] >= w_span);

    always_comb begin
        if (w_span_empty) begin
            w_eval_pct = (r_smooth >= r_full) ? blg_pkg::PCT_MAX : blg_pkg::PCT_MIN;
        end else if (w_diff_neg) begin
            w_eval_pct = blg_pkg::PCT_MIN;
        end else begin
            w_eval_pct = blg_pkg::PCT_MAX;
        end
    end

    assign w_div_start = i_cmd.pct_start;
    assign w_div_num   = blg_pkg::NUM_W'(r_diff) * blg_pkg::PCT_SCALE;
    assign w_div_den   = w_span;

    blg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_q     (w_q),
        .o_done  (w_div_done)
    );

    assign w_out_free = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full   <= blg_pkg::FULL_RST;
            r_empty  <= blg_pkg::EMPTY_RST;
            r_charge <= blg_pkg::CHARGE_RST;
            r_sum    <= '0;
            r_cnt    <= '0;
            r_smooth <= '0;
            r_primed <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    blg_pkg::REG_FULL:   r_full   <= i_cfg_data;
                    blg_pkg::REG_EMPTY:  r_empty  <= i_cfg_data;
                    blg_pkg::REG_CHARGE: r_charge <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.acc) begin
                r_sum <= r_sum + SUM_W'(i_pin_mv);
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.mean) begin
                r_sum <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.ema) begin
                r_smooth <= r_primed ? w_ema[blg_pkg::MV_W-1:0] : w_bat;
                r_primed <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (i_cmd.mean) begin
            r_mean <= w_mean;
        end
        if (i_cmd.eval) begin
            r_pct  <= w_eval_pct;
            r_diff <= w_diff[blg_pkg::MV_W-1:0];
        end else if (i_cmd.pct_load) begin
            r_pct  <= w_q[blg_pkg::PCT_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_opct <= r_pct;
            r_ochg <= (r_smooth >= r_charge);
            r_omv  <= r_smooth;
        end
    end

    assign o_stat.last_in_group = (r_cnt == CNT_W'(GROUP_SIZE - 1));
    assign o_stat.div_done      = w_div_done;
    assign o_stat.need_div      = !w_span_empty && !w_diff_neg && !w_diff_ge;
    assign o_stat.out_free      = w_out_free;

    assign o_out_valid  = r_ovalid;
    assign o_percent    = r_opct;
    assign o_charging   = r_ochg;
    assign o_battery_mv = r_omv;

endmodule

// ===== rtl/blg_ctrl.sv =====
// controller: sequences accumulate, mean, average update and percent divide
// depends on blg_pkg
`timescale 1ns / 1ps

module blg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  blg_pkg::t_dp_stat i_stat,
    output blg_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE       = 7'b000_0001,
        S_MEAN       = 7'b000_0010,
        S_EMA        = 7'b000_0100,
        S_EVAL       = 7'b000_1000,
        S_PCT_START  = 7'b001_0000,
        S_PCT_WAIT   = 7'b010_0000,
        S_OUT        = 7'b100_0000
    } t_state;

    t_state r_state, n_state;
    logic   w_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.acc = w_acc;
                if (w_acc && i_stat.last_in_group) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                o_cmd.mean = 1'b1;
                n_state = S_EMA;
            end
            S_EMA: begin
                o_cmd.ema = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state = i_stat.need_div ? S_PCT_START : S_OUT;
            end
            S_PCT_START: begin
                o_cmd.pct_start = 1'b1;
                n_state = S_PCT_WAIT;
            end
            S_PCT_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.pct_load = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/battery_level_gauge_top.sv =====
// battery level gauge: one item per cycle while a group fills; the item that closes a
// group starts the work (mean, average update, percent check and a percent divide) before
// the result is valid; the percent divide is skipped when no divide is needed
// no item is taken during that work or while the new result waits for the output register
// reset is synchronous, active low, and restores the config defaults and clears the average
`timescale 1ns / 1ps

module battery_level_gauge_top #(
    parameter int GROUP_SIZE = blg_pkg::GROUP_SIZE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [blg_pkg::IDX_W-1:0]          i_cfg_idx,
    input  logic [blg_pkg::MV_W-1:0]           i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [blg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // pin_mv
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [blg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata    // percent, charging, battery_mv
);

    blg_pkg::t_dp_cmd          w_cmd;
    blg_pkg::t_dp_stat         w_stat;
    logic [blg_pkg::PCT_W-1:0] w_percent;
    logic                      w_charging;
    logic [blg_pkg::MV_W-1:0]  w_battery_mv;

    blg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    blg_dp #(
        .GROUP_SIZE (GROUP_SIZE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_pin_mv     (s_axis_tdata[blg_pkg::PIN_W-1:0]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_percent    (w_percent),
        .o_charging   (w_charging),
        .o_battery_mv (w_battery_mv)
    );

    assign m_axis_tdata = {2'b00, w_battery_mv, w_charging, w_percent};

endmodule
